@@ hw/rtl/firdl_pkg.sv @@
// Shared types and constants for the FIR filter with delay line.
// Item structs, opcode and state enums, accumulator limits.
// No dependencies.
`default_nettype none

package firdl_pkg;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [5:0]        tap_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] filtered_sample;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Control carried alongside each multiply-accumulate operand pair.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  localparam int ACC_W = 40;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;

  localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] OUT_MIN = 16'sh8000;

  localparam logic [2:0] ADDR_TAP_COUNT = 3'd0;
  localparam logic [6:0] TAP_COUNT_RESET = 7'd64;

endpackage

`default_nettype wire

@@ hw/rtl/firdl_cell.sv @@
// One cell of the sample delay line: holds one sample and takes its
// neighbour's value on every shift. Depends on nothing.
`default_nettype none

module firdl_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic signed [15:0] d,
  output logic signed [15:0]      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/firdl_coef_ram.sv @@
// Coefficient store: one write port, one registered read port, and a
// valid bit per entry so unwritten entries read as zero after reset.
`default_nettype none

module firdl_coef_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               we,
  input  wire logic [AddrW-1:0]   waddr,
  input  wire logic signed [15:0] wdata,
  input  wire logic [AddrW-1:0]   raddr,
  output logic signed [15:0]      rdata
);

  logic signed [15:0] mem [Depth];
  logic [Depth-1:0]   written;
  logic signed [15:0] mem_q;
  logic               written_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      written_q <= written[raddr];
    end
  end

  assign rdata = written_q ? mem_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/firdl_mac.sv @@
// Multiply-accumulate unit: registered Q2.30 product, 40-bit saturating
// accumulator, then round half up and clip to Q1.15. Uses firdl_pkg.
`default_nettype none

module firdl_mac (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire firdl_pkg::mac_ctl_t  ctl,
  input  wire logic signed [15:0]   coef,
  input  wire logic signed [15:0]   sample,
  output logic                      done,
  output firdl_pkg::out_item_t      result
);

  import firdl_pkg::*;

  mac_ctl_t                  ctl_p;
  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  logic                      clip;

  logic signed [ACC_W:0]     acc_base;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic                      clip_next;
  logic signed [ACC_W:0]     rounded;
  logic signed [ACC_W:0]     scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_p <= ctl;
      done  <= ctl_p.valid & ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef * sample;
  end

  // Saturating add: clip after every product.
  always_comb begin
    acc_base  = ctl_p.first ? '0 : (ACC_W+1)'(acc);
    sum       = acc_base + (ACC_W+1)'(prod);
    clip_next = ctl_p.first ? 1'b0 : clip;
    if (sum > (ACC_W+1)'(ACC_MAX)) begin
      acc_next  = ACC_MAX;
      clip_next = 1'b1;
    end else if (sum < (ACC_W+1)'(ACC_MIN)) begin
      acc_next  = ACC_MIN;
      clip_next = 1'b1;
    end else begin
      acc_next  = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_p.valid) begin
      acc  <= acc_next;
      clip <= clip_next;
    end
  end

  // Round half up to Q1.15, then clip to 16 bits.
  always_comb begin
    rounded = (ACC_W+1)'(acc) + (ACC_W+1)'(16384);
    scaled  = rounded >>> 15;
    result.saturated = clip;
    if (scaled > (ACC_W+1)'(OUT_MAX)) begin
      result.filtered_sample = OUT_MAX;
      result.saturated       = 1'b1;
    end else if (scaled < (ACC_W+1)'(OUT_MIN)) begin
      result.filtered_sample = OUT_MIN;
      result.saturated       = 1'b1;
    end else begin
      result.filtered_sample = scaled[15:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fir_filter_with_delay_line.sv @@
// A sample transfer rotates the ring through the SKIP and RUN states, waits in DRAIN
// for the multiply-accumulate, then loads the result in EMIT; the input stalls until
// IDLE again, more while a stalled result holds the output. Loads do not stall it.
// The delay line is a ring of cells turned MaxTaps steps per sample, the active
// taps feeding one shared multiply-accumulate. Synchronous reset clears the delay
// line and coefficient valid bits and sets tap_count to 64; no clearing pass.
`default_nettype none

module fir_filter_with_delay_line #(
  parameter int MaxTaps = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire firdl_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output firdl_pkg::out_item_t      out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import firdl_pkg::*;

  localparam int AW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
  localparam int CW = $clog2(MaxTaps + 1);

  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic [6:0]         tap_count;
  logic [CW-1:0]      taps;
  logic [CW-1:0]      skip;

  logic               accept;
  logic               push;
  logic               coef_we;
  logic               rotate;
  logic               issue;
  logic               out_load;
  logic               skip_last;
  logic               run_last;
  logic [31:0]        idx_ext;

  logic signed [15:0] tap_q [MaxTaps];
  logic signed [15:0] sample_q;
  logic signed [15:0] coef_rd;
  mac_ctl_t           issue_ctl;
  mac_ctl_t           ctl_q;
  logic               mac_done;
  out_item_t          mac_result;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_TAP_COUNT[2]) begin
      tap_count <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_TAP_COUNT[2]) ? 32'(tap_count) : '0;

  // Clamp the tap count to 1..MaxTaps
  always_comb begin
    if (tap_count == '0) begin
      taps = CW'(1);
    end else if (int'(tap_count) > MaxTaps) begin
      taps = CW'(MaxTaps);
    end else begin
      taps = CW'(tap_count);
    end
    skip = CW'(MaxTaps) - taps;
  end

  assign accept    = in_valid && !in_stall;
  assign push      = accept && in_data.op == OP_SAMPLE;
  assign idx_ext   = 32'(in_data.tap_index);
  assign coef_we   = accept && in_data.op == OP_LOAD && int'(in_data.tap_index) < MaxTaps;
  assign skip_last = cnt == skip - CW'(1);
  assign run_last  = cnt == taps - CW'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (push) begin
          state_next = (skip == '0) ? ST_RUN : ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    rotate   = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    cnt_next = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SKIP: begin
        rotate   = 1'b1;
        cnt_next = skip_last ? '0 : cnt + CW'(1);
      end
      ST_RUN: begin
        rotate   = 1'b1;
        issue    = 1'b1;
        cnt_next = cnt + CW'(1);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Delay line: shift in on a sample, turn as a ring while filtering
  for (genvar k = 0; k < MaxTaps; k++) begin : g_line
    logic signed [15:0] d;
    if (k == 0) begin : g_head
      assign d = push ? in_data.value : tap_q[MaxTaps-1];
    end else begin : g_body
      assign d = tap_q[k-1];
    end
    firdl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (push || rotate),
      .d     (d),
      .q     (tap_q[k])
    );
  end

  firdl_coef_ram #(
    .Depth (MaxTaps),
    .AddrW (AW)
  ) u_coef_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (in_data.value),
    .raddr (cnt[AW-1:0]),
    .rdata (coef_rd)
  );

  // Align the sample with the registered coefficient read
  always_comb begin
    issue_ctl.valid = issue;
    issue_ctl.first = issue && cnt == '0;
    issue_ctl.last  = issue && run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= issue_ctl;
    end
  end

  always_ff @(posedge clk) begin
    sample_q <= tap_q[MaxTaps-1];
  end

  firdl_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_q),
    .coef   (coef_rd),
    .sample (sample_q),
    .done   (mac_done),
    .result (mac_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= mac_result;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/firdl_checker.sv @@
// Port-level checks for fir_filter_with_delay_line, attached by bind.
// Uses firdl_pkg.
`default_nettype none

module firdl_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire firdl_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire firdl_pkg::out_item_t out_data
);

  import firdl_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A sample transfer starts filtering, so the input stalls next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_SAMPLE |=> in_stall)
    else $error("input not stalled while filtering");

  // A coefficient load leaves the input unstalled in the next cycle
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == OP_LOAD |=> !in_stall)
    else $error("input stalled after coefficient load");

  // Any clip drives the output to a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.filtered_sample == OUT_MAX || out_data.filtered_sample == OUT_MIN)
    else $error("saturated flag without a clipped value");

endmodule

bind fir_filter_with_delay_line firdl_checker u_firdl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ sim/fir_output_checker.sv @@
// Checker for the FIR filter: watches the input, output and register ports,
// keeps its own delay line, coefficients and tap count, and compares each output.
// Depends on firdl_pkg for the item types and register constants.
module fir_output_checker
  import firdl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_item_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_item_t   out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               pending
);

  localparam int MaxTaps = 64;
  localparam longint AccHigh = longint'(ACC_MAX);
  localparam longint AccLow  = longint'(ACC_MIN);

  logic signed [15:0] history [MaxTaps];
  logic signed [15:0] coefs [MaxTaps];
  int                 write_pos = 0;
  logic [6:0]         tap_count = TAP_COUNT_RESET;
  out_item_t          pending_outputs [$];
  int                 fail_count = 0;

  // Output for the sample just written; coefficient 0 meets the oldest sample.
  function automatic out_item_t filter_output();
    longint    acc;
    longint    rounded;
    int        taps;
    int        slot;
    logic      clip;
    out_item_t result;
    if (tap_count == 0) begin
      taps = 1;
    end else if (tap_count > MaxTaps) begin
      taps = MaxTaps;
    end else begin
      taps = tap_count;
    end
    acc  = 0;
    clip = 1'b0;
    for (int j = 0; j < taps; j++) begin
      slot = (write_pos + MaxTaps - taps + j) % MaxTaps;
      acc += longint'(int'(coefs[j]) * int'(history[slot]));
      if (acc > AccHigh) begin
        acc  = AccHigh;
        clip = 1'b1;
      end else if (acc < AccLow) begin
        acc  = AccLow;
        clip = 1'b1;
      end
    end
    rounded = (acc + 64'sd16384) >>> 15;
    if (rounded > longint'(OUT_MAX)) begin
      rounded = longint'(OUT_MAX);
      clip    = 1'b1;
    end else if (rounded < longint'(OUT_MIN)) begin
      rounded = longint'(OUT_MIN);
      clip    = 1'b1;
    end
    result.filtered_sample = rounded[15:0];
    result.saturated       = clip;
    return result;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < MaxTaps; i++) begin
        history[i] = '0;
        coefs[i]   = '0;
      end
      write_pos = 0;
      tap_count = TAP_COUNT_RESET;
      pending_outputs.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TAP_COUNT) begin
        tap_count = pwdata[6:0];
      end
      if (in_valid && !in_stall) begin
        if (in_data.op == OP_LOAD) begin
          coefs[in_data.tap_index] = in_data.value;
        end else begin
          history[write_pos] = in_data.value;
          write_pos = (write_pos + 1) % MaxTaps;
          pending_outputs.push_back(filter_output());
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: output with none expected: filtered_sample %0d saturated %0b",
                   $time, out_data.filtered_sample, out_data.saturated);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_data.filtered_sample !== want.filtered_sample) begin
            $display("%0t: filtered_sample expected %0d actual %0d",
                     $time, want.filtered_sample, out_data.filtered_sample);
            fail_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, out_data.saturated);
            fail_count++;
          end
        end
      end
    end
    mismatches <= fail_count;
    pending    <= pending_outputs.size();
  end

endmodule

@@ sim/tb.sv @@
// Top of the FIR filter testbench: clock, reset, stimulus and verdict.
// Drives directed and random transfers through several tap counts and idle mixes;
// depends on firdl_pkg, fir_filter_with_delay_line and fir_output_checker.
module tb;
  import firdl_pkg::*;

  localparam int ItemsPerPhase = 165;
  localparam int Phases        = 10;
  localparam int SettleCycles  = 100;
  localparam int QuietLimit    = 4000;
  // Address of register index 1, which does not exist
  localparam logic [2:0] ADDR_NO_REG = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  fir_filter_with_delay_line dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fir_output_checker out_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t item_of(op_t op, logic [5:0] idx, logic [15:0] v);
    in_item_t item;
    item.op        = op;
    item.tap_index = idx;
    item.value     = v;
    return item;
  endfunction

  function automatic logic [15:0] random_value();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input in_item_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every output, then let any load still in flight finish
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 20) begin
      send(item_of(OP_LOAD, 6'($urandom), random_value()));
    end else begin
      send(item_of(OP_SAMPLE, 6'($urandom), random_value()));
    end
  endtask

  initial begin
    int taps;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset tap count: early zeros, rounding, both clip directions
    send(item_of(OP_SAMPLE, 6'd0,  16'h7FFF));
    send(item_of(OP_LOAD,   6'd63, 16'h8000));
    send(item_of(OP_SAMPLE, 6'h3F, 16'h8000));
    send(item_of(OP_SAMPLE, 6'd0,  16'h7FFF));
    send(item_of(OP_LOAD,   6'd63, 16'h4000));
    send(item_of(OP_SAMPLE, 6'h15, 16'h0001));
    send(item_of(OP_SAMPLE, 6'h2A, 16'hFFFF));
    send(item_of(OP_LOAD,   6'd62, 16'h7FFF));
    send(item_of(OP_SAMPLE, 6'd0,  16'h0000));
    send(item_of(OP_LOAD,   6'd0,  16'h7FFF));
    send(item_of(OP_LOAD,   6'd61, 16'h7FFF));
    send(item_of(OP_LOAD,   6'd60, 16'h7FFF));
    repeat (4) send(item_of(OP_SAMPLE, 6'd0, 16'h8000));
    send(item_of(OP_LOAD,   6'h2A, 16'h5555));
    send(item_of(OP_LOAD,   6'h15, 16'hAAAA));
    send(item_of(OP_SAMPLE, 6'h3F, 16'h5555));
    send(item_of(OP_SAMPLE, 6'h00, 16'hAAAA));
    send(item_of(OP_SAMPLE, 6'h2A, 16'h7FFF));
    in_valid <= 1'b0;

    for (int p = 0; p < Phases; p++) begin
      settle();
      case (p)
        0: taps = 1;
        1: taps = 0;
        2: taps = 64;
        3: taps = 127;
        4: taps = 65;
        default: taps = $urandom_range(2, 63);
      endcase
      if (p == 5) begin
        write_reg(ADDR_NO_REG, 32'd3);
      end
      write_reg(ADDR_TAP_COUNT, 32'(taps));
      case (p % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 54;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 54;
        end
        default: begin
          send_idle  = 36;
          recv_stall = 36;
        end
      endcase
      repeat (ItemsPerPhase) random_item();
      in_valid <= 1'b0;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
